>>> design/scar_pkg.sv
// Package for the stereo comb/allpass reverb: payload structs, constants,
// delay tables and fixed-point helpers. Used by every module in design/.
`default_nettype none
package scar_pkg;

  localparam int SampleW        = 24;
  localparam int CombDepthDef   = 4096;
  localparam int ApDepthDef     = 2048;
  localparam int CombCountDef   = 8;
  localparam int ApCountDef     = 4;
  localparam int ScaleW         = 10;
  localparam logic [ScaleW-1:0] ScaleReset = 10'd256;
  localparam logic signed [19:0] SendGain  = 20'sd251658;
  localparam int Spread         = 23;

  typedef struct packed {
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
    logic [15:0]        room_feedback;
    logic [15:0]        damping;
    logic [15:0]        wet_mix;
    logic [15:0]        stereo_width;
  } in_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
  } out_t;

  // Per-item parameters handed to each lane.
  typedef struct packed {
    logic signed [31:0] send;
    logic [15:0]        room;
    logic [15:0]        damp;
    logic [ScaleW-1:0]  scale;
  } lane_cmd_t;

  function automatic logic [11:0] comb_base(input logic [2:0] j);
    case (j)
      3'd0: comb_base = 12'd1617;
      3'd1: comb_base = 12'd1557;
      3'd2: comb_base = 12'd1491;
      3'd3: comb_base = 12'd1422;
      3'd4: comb_base = 12'd1356;
      3'd5: comb_base = 12'd1277;
      3'd6: comb_base = 12'd1188;
      default: comb_base = 12'd1116;
    endcase
  endfunction

  function automatic logic [11:0] ap_base(input logic [1:0] j);
    case (j)
      2'd0: ap_base = 12'd225;
      2'd1: ap_base = 12'd556;
      2'd2: ap_base = 12'd441;
      default: ap_base = 12'd341;
    endcase
  endfunction

  // Scaled delay, raised to 1 and cut to the line depth.
  function automatic logic [15:0] scaled_delay(input logic [11:0] base,
      input logic [ScaleW-1:0] scale, input logic ch, input logic [15:0] depth);
    logic [21:0] prod;
    logic [15:0] raw;
    prod = base * scale;
    raw = {2'b00, prod[21:8]} + (ch ? 16'(Spread) : 16'd0);
    if (raw < 16'd1) raw = 16'd1;
    if (raw > depth) raw = depth;
    return raw;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // floor((v + 2^15) / 2^16)
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd32768;
    return t >>> 16;
  endfunction

endpackage
`default_nettype wire

>>> design/stereo_comb_allpass_reverb_core.sv
// Stereo reverb top level: send, two channel lanes and the output mix.
// Depends on scar_pkg, scar_lane, scar_mix.
//
//  channel  | direction | handshake
//  in       | input     | in_valid / in_stall (out)
//  out      | output    | out_valid / out_stall (in)
//  cfg      | input     | cfg_valid / cfg_ready (out)
//
// An item's processing time is set by the sequential comb and allpass
// memory accesses in each lane.
// After reset the delay memories are swept clear, one word a cycle, across
// max(COMB_COUNT*COMB_LINE_DEPTH, ALLPASS_COUNT*ALLPASS_LINE_DEPTH) words,
// with the input stalled meanwhile.
// A finished result waits in the output register; a new item is accepted
// meanwhile and its result waits until the old one is taken.
`default_nettype none
module stereo_comb_allpass_reverb_core #(
  parameter int COMB_LINE_DEPTH = scar_pkg::CombDepthDef,
  parameter int ALLPASS_LINE_DEPTH = scar_pkg::ApDepthDef,
  parameter int COMB_COUNT = scar_pkg::CombCountDef,
  parameter int ALLPASS_COUNT = scar_pkg::ApCountDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire scar_pkg::in_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output scar_pkg::out_t out_data,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [scar_pkg::ScaleW-1:0] cfg_data
);
  import scar_pkg::*;

  logic [ScaleW-1:0] length_scale;
  logic busy, pend, lane_go;
  in_t item;
  lane_cmd_t cmd;
  logic done_l, done_r, mix_done;
  logic idle_l, idle_r;
  logic signed [31:0] wet_l, wet_r;
  logic signed [44:0] send_p;
  out_t res;

  assign cfg_ready = 1'b1;
  assign in_stall = busy || pend || !(idle_l && idle_r);

  // Hold the length register.
  always_ff @(posedge clk) begin
    if (rst) length_scale <= ScaleReset;
    else if (cfg_valid) length_scale <= cfg_data;
  end

  // Accept an item, form the send, start both lanes, wait for the mix, load the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      lane_go <= 1'b0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      lane_go <= 1'b0;
      if (in_valid && !in_stall) begin
        item <= in_data;
        send_p <= (45'(in_data.left_in) + 45'(in_data.right_in)) * 45'(SendGain);
        busy <= 1'b1;
        lane_go <= 1'b1;
      end
      if (mix_done) begin
        busy <= 1'b0;
        pend <= 1'b1;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (pend && (!out_valid || !out_stall)) begin
        out_data <= res;
        out_valid <= 1'b1;
        pend <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd.send = 32'((send_p + 45'sd8388608) >>> 24);
    cmd.room = item.room_feedback;
    cmd.damp = item.damping;
    cmd.scale = length_scale;
  end

  scar_lane #(.CH(1'b0), .COMB_LINE_DEPTH(COMB_LINE_DEPTH),
    .ALLPASS_LINE_DEPTH(ALLPASS_LINE_DEPTH), .COMB_COUNT(COMB_COUNT),
    .ALLPASS_COUNT(ALLPASS_COUNT)) u_left (
    .clk(clk), .rst(rst), .start(lane_go), .cmd(cmd), .idle(idle_l), .done(done_l),
    .wet(wet_l));

  scar_lane #(.CH(1'b1), .COMB_LINE_DEPTH(COMB_LINE_DEPTH),
    .ALLPASS_LINE_DEPTH(ALLPASS_LINE_DEPTH), .COMB_COUNT(COMB_COUNT),
    .ALLPASS_COUNT(ALLPASS_COUNT)) u_right (
    .clk(clk), .rst(rst), .start(lane_go), .cmd(cmd), .idle(idle_r), .done(done_r),
    .wet(wet_r));

  scar_mix u_mix (
    .clk(clk), .rst(rst), .go(done_l), .item(item), .wet_l(wet_l), .wet_r(wet_r),
    .ready_pulse(mix_done), .res(res));

`ifndef ASSERT_OFF
  a_lanes_sync: assert property (@(posedge clk) disable iff (rst)
    done_l == done_r) else $error("lanes out of step");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("accepted while busy");
  a_mix_busy: assert property (@(posedge clk) disable iff (rst)
    mix_done |-> busy) else $error("result without item");
`endif
endmodule
`default_nettype wire

>>> design/scar_lane.sv
// One channel lane: COMB_COUNT combs then ALLPASS_COUNT allpasses, run
// step by step through one comb memory and one allpass memory.
// Depends on scar_pkg.
`default_nettype none
module scar_lane #(
  parameter logic CH = 1'b0,
  parameter int COMB_LINE_DEPTH = 4096,
  parameter int ALLPASS_LINE_DEPTH = 2048,
  parameter int COMB_COUNT = 8,
  parameter int ALLPASS_COUNT = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire scar_pkg::lane_cmd_t cmd,
  output logic idle,
  output logic done,
  output logic signed [31:0] wet
);
  import scar_pkg::*;

  localparam int CAW = $clog2(COMB_LINE_DEPTH);
  localparam int AAW = $clog2(ALLPASS_LINE_DEPTH);
  localparam int CIW = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
  localparam int AIW = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
  localparam int CMW = $clog2(COMB_COUNT * COMB_LINE_DEPTH);
  localparam int AMW = $clog2(ALLPASS_COUNT * ALLPASS_LINE_DEPTH);
  localparam int CWORDS = COMB_COUNT * COMB_LINE_DEPTH;
  localparam int AWORDS = ALLPASS_COUNT * ALLPASS_LINE_DEPTH;
  localparam int CLRW = (CMW > AMW) ? CMW + 1 : AMW + 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CRD  = 4'd2;
  localparam logic [3:0] S_CM1  = 4'd3;
  localparam logic [3:0] S_CM2  = 4'd4;
  localparam logic [3:0] S_CWR  = 4'd5;
  localparam logic [3:0] S_ARD  = 4'd6;
  localparam logic [3:0] S_AWR  = 4'd7;

  logic [3:0] state;
  logic [CLRW-1:0] clr_cnt;
  logic [CIW-1:0] ci;
  logic [AIW-1:0] ai;
  logic [CAW:0] cpos [COMB_COUNT];
  logic [AAW:0] apos [ALLPASS_COUNT];
  logic signed [31:0] lp [COMB_COUNT];
  logic signed [31:0] cmem [CWORDS];
  logic signed [31:0] amem [AWORDS];
  logic signed [31:0] crd, ard;
  logic signed [31:0] acc_s;
  logic signed [35:0] acc;
  logic signed [63:0] p1, p2;
  logic signed [31:0] lpv;
  lane_cmd_t c;

  logic [15:0] cdl, adl;
  logic [CAW:0] cp_eff, cp_inc;
  logic [AAW:0] ap_eff, ap_inc;
  logic [CMW-1:0] caddr;
  logic [AMW-1:0] aaddr;
  logic signed [31:0] half;

  always_comb begin
    cdl = scaled_delay(comb_base(3'(ci)), c.scale, CH, 16'(COMB_LINE_DEPTH));
    adl = scaled_delay(ap_base(2'(ai)), c.scale, CH, 16'(ALLPASS_LINE_DEPTH));
    cp_eff = ({{(16-CAW-1){1'b0}}, cpos[ci]} >= cdl) ? '0 : cpos[ci];
    ap_eff = ({{(16-AAW-1){1'b0}}, apos[ai]} >= adl) ? '0 : apos[ai];
    cp_inc = ({{(16-CAW-1){1'b0}}, cp_eff} + 16'd1 >= cdl) ? '0 : cp_eff + 1'b1;
    ap_inc = ({{(16-AAW-1){1'b0}}, ap_eff} + 16'd1 >= adl) ? '0 : ap_eff + 1'b1;
    caddr = CMW'(ci * COMB_LINE_DEPTH) + CMW'(cp_eff[CAW-1:0]);
    aaddr = AMW'(ai * ALLPASS_LINE_DEPTH) + AMW'(ap_eff[AAW-1:0]);
    half = 32'((64'(ard) + 64'sd1) >>> 1);
  end

  // Hold the memories: clear sweep, then one read and one write per step.
  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      if (clr_cnt < CLRW'(CWORDS)) cmem[clr_cnt[CMW-1:0]] <= '0;
      if (clr_cnt < CLRW'(AWORDS)) amem[clr_cnt[AMW-1:0]] <= '0;
    end else begin
      if (state == S_CWR)
        cmem[caddr] <= sat32(64'(c.send) + rnd16(64'(lpv) * $signed({1'b0, c.room})));
      if (state == S_AWR) amem[aaddr] <= sat32(64'(acc_s) + 64'(half));
    end
    crd <= cmem[caddr];
    ard <= amem[aaddr];
  end

  // Advance the comb and allpass sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      done <= 1'b0;
      ci <= '0;
      ai <= '0;
      for (int k = 0; k < COMB_COUNT; k++) begin
        cpos[k] <= '0;
        lp[k] <= '0;
      end
      for (int k = 0; k < ALLPASS_COUNT; k++) apos[k] <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLRW'(CWORDS > AWORDS ? CWORDS - 1 : AWORDS - 1))
            state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          c <= cmd;
          ci <= '0;
          ai <= '0;
          acc <= '0;
          state <= S_CRD;
        end
        S_CRD: state <= S_CM1;
        S_CM1: begin
          acc <= acc + 36'(crd);
          p1 <= 64'(crd) * $signed({1'b0, 17'(17'd65536 - {1'b0, c.damp})});
          p2 <= 64'(lp[ci]) * $signed({1'b0, c.damp});
          state <= S_CM2;
        end
        S_CM2: begin
          lpv <= sat32(rnd16(p1 + p2));
          state <= S_CWR;
        end
        S_CWR: begin
          lp[ci] <= lpv;
          cpos[ci] <= cp_inc;
          if (ci == CIW'(COMB_COUNT - 1)) begin
            acc_s <= sat32(64'(acc));
            state <= S_ARD;
          end else begin
            ci <= ci + 1'b1;
            state <= S_CRD;
          end
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          acc_s <= sat32(64'(half) - 64'(acc_s));
          apos[ai] <= ap_inc;
          if (ai == AIW'(ALLPASS_COUNT - 1)) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            ai <= ai + 1'b1;
            state <= S_ARD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign wet = acc_s;
  assign idle = (state == S_IDLE);

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE) else $error("lane started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
`endif
endmodule
`default_nettype wire

>>> design/scar_mix.sv
// Merging stage: cross-mix the two lane results with the dry input and
// saturate to the sample width. Depends on scar_pkg.
`default_nettype none
module scar_mix (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic go,
  input  wire scar_pkg::in_t item,
  input  wire logic signed [31:0] wet_l,
  input  wire logic signed [31:0] wet_r,
  output logic ready_pulse,
  output scar_pkg::out_t res
);
  import scar_pkg::*;

  logic [1:0] step;
  logic [16:0] dry, w1, w2;
  logic signed [63:0] sl, sr;
  logic [33:0] pw1, pw2;
  logic signed [63:0] tl, tr;

  function automatic logic signed [SampleW-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] hi;
    hi = (64'sd1 <<< (SampleW - 1)) - 64'sd1;
    if (v > hi) v = hi;
    if (v < -hi - 64'sd1) v = -hi - 64'sd1;
    return v[SampleW-1:0];
  endfunction

  // Sequence: gains, then products, then round and saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      ready_pulse <= 1'b0;
    end else begin
      ready_pulse <= 1'b0;
      case (step)
        2'd0: if (go) begin
          dry <= 17'd65536 - {1'b0, item.wet_mix};
          pw1 <= item.wet_mix * (17'd65536 + {1'b0, item.stereo_width});
          pw2 <= item.wet_mix * (17'd65536 - {1'b0, item.stereo_width});
          step <= 2'd1;
        end
        2'd1: begin
          w1 <= 17'((pw1 + 34'd65536) >> 17);
          w2 <= 17'((pw2 + 34'd65536) >> 17);
          step <= 2'd2;
        end
        2'd2: begin
          sl <= 64'(item.left_in) * $signed({1'b0, dry}) + 64'(wet_l) * $signed({1'b0, w1})
              + 64'(wet_r) * $signed({1'b0, w2});
          sr <= 64'(item.right_in) * $signed({1'b0, dry}) + 64'(wet_r) * $signed({1'b0, w1})
              + 64'(wet_l) * $signed({1'b0, w2});
          step <= 2'd3;
        end
        default: begin
          res.left_out <= sat_out(tl);
          res.right_out <= sat_out(tr);
          ready_pulse <= 1'b1;
          step <= 2'd0;
        end
      endcase
    end
  end

  assign tl = rnd16(sl);
  assign tr = rnd16(sr);

`ifndef ASSERT_OFF
  a_ready: assert property (@(posedge clk) disable iff (rst)
    ready_pulse |-> $past(step) == 2'd3) else $error("result out of sequence");
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    ready_pulse |=> !ready_pulse) else $error("result pulse held");
  a_go: assert property (@(posedge clk) disable iff (rst)
    (step != 2'd0) |=> !ready_pulse || $past(step) == 2'd3) else $error("mix step slip");
`endif
endmodule
`default_nettype wire
